### hdl/button_debounce_hold_mode_control_top_macros.svh
// assertion macros for the button debounce and hold mode control block
`ifndef BUTTON_DEBOUNCE_HOLD_MODE_CONTROL_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_MODE_CONTROL_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define BDHM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bdhm_pkg.sv
// shared types, codes and helpers for the button debounce and hold mode control block
`default_nettype none

package bdhm_pkg;

  localparam int MODE_COUNT = 4;

  localparam int DEB_W  = 8;
  localparam int HOLD_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SCANS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SCANS     = 2'd1;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd3;
  localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd75;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ACTIVATE = 3'd1;
  localparam logic [2:0] ACT_BEGIN    = 3'd2;
  localparam logic [2:0] ACT_CANCEL   = 3'd3;
  localparam logic [2:0] ACT_COMMIT   = 3'd4;

  localparam logic [1:0] RING_OFF = 2'd0;
  localparam logic [1:0] RING_ON  = 2'd1;

  typedef struct packed {
    logic       button_level;
    logic [1:0] ring_status;
    logic [3:0] ring_mode;
    logic       begin_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] target_mode;
    logic       deb_pressed;
  } out_item_t;

  // next mode with wrap; at most eight narrow compare/subtract steps
  function automatic logic [3:0] mode_after(input logic [3:0] mode);
    logic [4:0] s;
    s = {1'b0, mode} + 5'd1;
    for (int i = 0; i < 8; i++) begin
      if (s >= 5'(MODE_COUNT)) begin
        s = s - 5'(MODE_COUNT);
      end
    end
    return s[3:0];
  endfunction

endpackage

`default_nettype wire

### hdl/bdhm_core.sv
// debounce state, press timing and action decision for one scan
`default_nettype none

module bdhm_core
  import bdhm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire in_item_t          item,
  input  wire logic [DEB_W-1:0]  debounce_scans,
  input  wire logic [HOLD_W-1:0] hold_scans,
  output out_item_t              result
);

  logic              raw_last_r, raw_last_nxt;
  logic              debounced_r, debounced_nxt;
  logic              pending_r, pending_nxt;
  logic [DEB_W-1:0]  edge_age_r, edge_age_nxt;
  logic [HOLD_W-1:0] press_age_r, press_age_nxt;

  logic              pressed;
  logic [DEB_W-1:0]  edge_inc;
  logic [HOLD_W-1:0] press_inc;
  logic              take;

  assign pressed   = ~item.button_level;
  assign edge_inc  = (&edge_age_r) ? edge_age_r : edge_age_r + 1'b1;
  assign press_inc = (&press_age_r) ? press_age_r : press_age_r + 1'b1;

  always_comb begin
    raw_last_nxt  = pressed;
    edge_age_nxt  = (pressed != raw_last_r) ? '0 : edge_inc;
    debounced_nxt = debounced_r;
    pending_nxt   = pending_r;
    press_age_nxt = press_inc;
    result.action      = ACT_NONE;
    result.target_mode = 4'd0;
    take = (pressed != debounced_r) && (edge_age_nxt >= debounce_scans);
    if (take) begin
      debounced_nxt = pressed;
      if (pressed) begin
        press_age_nxt = '0;
        pending_nxt   = 1'b0;
        if (item.ring_status == RING_OFF) begin
          result.action      = ACT_ACTIVATE;
          result.target_mode = item.ring_mode;
        end else if (item.ring_status == RING_ON) begin
          result.action      = ACT_BEGIN;
          result.target_mode = mode_after(item.ring_mode);
          pending_nxt        = item.begin_ok;
        end
      end else if (pending_r) begin
        result.action = (press_inc < hold_scans) ? ACT_CANCEL : ACT_COMMIT;
        pending_nxt   = 1'b0;
      end
    end
    result.deb_pressed = debounced_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r  <= 1'b0;
      debounced_r <= 1'b0;
      pending_r   <= 1'b0;
      edge_age_r  <= '0;
      press_age_r <= '0;
    end else if (step) begin
      raw_last_r  <= raw_last_nxt;
      debounced_r <= debounced_nxt;
      pending_r   <= pending_nxt;
      edge_age_r  <= edge_age_nxt;
      press_age_r <= press_age_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/button_debounce_hold_mode_control_top.sv
// top level of the button debounce and hold mode control block: one scan
// sample in, one request out. each sample is debounced against the configured
// steady-scan count, and a qualified press asks the ring to activate (ring
// off) or to begin a change to the next mode (ring on); the release after an
// accepted begin asks for cancel or commit depending on the press length.
// a sample is taken every cycle when the result side keeps up: it lands in an
// input register, the decision logic runs on it from there and its request
// is held in the output register, which drives out_valid, until the result
// side takes it; throughput is one request per cycle while out_stall is low,
// set by the single decision stage that also updates the debounce and timing
// counters.
`default_nettype none
`include "button_debounce_hold_mode_control_top_macros.svh"

module button_debounce_hold_mode_control_top
  import bdhm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  // request channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [DEB_W-1:0]  debounce_scans_r;
  logic [HOLD_W-1:0] hold_scans_r;

  // input register
  logic     in_valid_r, in_valid_nxt;
  in_item_t in_item_r;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  logic      in_take;
  logic      advance;
  out_item_t result;

  // writes are always taken; the user must issue them only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_scans_r <= DEBOUNCE_RESET;
      hold_scans_r     <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_SCANS: debounce_scans_r <= cfg_data[DEB_W-1:0];
        CFG_HOLD_SCANS:     hold_scans_r     <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // the decision stage moves whenever the output slot is free or emptying
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  // debounce, press timing and the request decision; state moves per request
  bdhm_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .item           (in_item_r),
    .debounce_scans (debounce_scans_r),
    .hold_scans     (hold_scans_r),
    .result         (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // cancel and commit come only from a debounced release
  `BDHM_ASSERT_IMPLY(a_release_req,
    out_valid_r && (out_item_r.action == ACT_CANCEL || out_item_r.action == ACT_COMMIT),
    !out_item_r.deb_pressed, "release request while button held")
  // activate and begin come only from a debounced press
  `BDHM_ASSERT_IMPLY(a_press_req,
    out_valid_r && (out_item_r.action == ACT_ACTIVATE || out_item_r.action == ACT_BEGIN),
    out_item_r.deb_pressed, "press request while button released")
  // next mode always wraps into range
  `BDHM_ASSERT_IMPLY(a_begin_mode,
    out_valid_r && out_item_r.action == ACT_BEGIN,
    {1'b0, out_item_r.target_mode} < 5'(MODE_COUNT), "begin target out of range")
  // a decided request always lands in the output register
  `BDHM_ASSERT_NEXT(a_advance_lands, advance, out_valid_r, "decided request lost")

endmodule

`default_nettype wire
